// ===== rtl/whbi_pkg.sv =====
package whbi_pkg;

   localparam int KeyWidth   = 32;
   localparam int CountWidth = 3;
   localparam int HashWidth  = 64;
   localparam int IndexWidth = 24;
   localparam int SizeWidth  = 25;
   localparam int PrimeWidth = 12;

   localparam logic [HashWidth-1:0] HASH_SEED = 64'd5381;
   localparam logic [SizeWidth-1:0] TABLE_RESET = 25'd1024;
   localparam logic [SizeWidth-1:0] TABLE_MAX = 25'd16777216;
   localparam logic [CountWidth-1:0] FULL_COUNT = 3'd4;

   // Multipliers for the bytes of a short word, indexed by distance from the end.
   function automatic logic [PrimeWidth-1:0] tail_prime(input logic [1:0] idx);
      logic [PrimeWidth-1:0] p;
      case (idx)
         2'd0: p = 12'd2909;
         2'd1: p = 12'd3001;
         2'd2: p = 12'd3083;
         default: p = 12'd0;
      endcase
      return p;
   endfunction

endpackage

// ===== rtl/word_hash_bucket_index_core.sv =====
// A word is taken only while the sequencer is idle: a full word folds in with a single step,
// a short word of r bytes with one multiply-add per tail byte, and an empty word adds nothing.
// A last word then runs a bit-serial remainder loop over all 64 bits of the sum and loads the
// result into the output register; the next word can be taken once the result is loaded, and
// later still while a stalled output holds the previous result.
// Synchronous active-high reset clears control, sets the sum to 5381 and the table to 1024.
module word_hash_bucket_index_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [whbi_pkg::SizeWidth-1:0]    csr_table_size,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [whbi_pkg::KeyWidth-1:0]     req_key_word,
   input  logic [whbi_pkg::CountWidth-1:0]   req_byte_count,
   input  logic                              req_last_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [whbi_pkg::HashWidth-1:0]    rsp_hash_value,
   output logic [whbi_pkg::IndexWidth-1:0]   rsp_bucket_index
);
   import whbi_pkg::*;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_UPDATE = 2'd1;
   localparam logic [1:0] ST_DIVIDE = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [SizeWidth-1:0]  table_ff;
   logic [HashWidth-1:0]  sum_ff, sum_in;
   logic [KeyWidth-1:0]   word_ff, word_in;
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   logic                  last_ff, last_in;
   logic [HashWidth-1:0]  dvd_ff, dvd_in;
   logic [IndexWidth-1:0] rem_ff, rem_in;
   logic [5:0]            step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [HashWidth-1:0]  rsp_hash_ff, rsp_hash_in;
   logic [IndexWidth-1:0] rsp_index_ff, rsp_index_in;

   logic                  req_take;
   logic [CountWidth-1:0] count_clamp;
   logic [SizeWidth-1:0]  divisor;
   logic [SizeWidth-1:0]  trial;
   logic [SizeWidth-1:0]  trial_sub;
   logic signed [20:0]    tail_prod;
   logic [HashWidth-1:0]  tail_ext;
   logic [1:0]            prime_idx;
   logic                  out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Byte counts above four are treated as a full word.
   assign count_clamp = (req_byte_count > FULL_COUNT) ? FULL_COUNT : req_byte_count;

   // A table size of zero acts as one; sizes above the maximum are clipped.
   always_comb begin
      if (table_ff == '0) begin
         divisor = {{(SizeWidth-1){1'b0}}, 1'b1};
      end else if (table_ff > TABLE_MAX) begin
         divisor = TABLE_MAX;
      end else begin
         divisor = table_ff;
      end
   end

   // The single multiply-add handles one tail byte per cycle. The count register
   // counts down, so it also gives the distance of the current byte from the end.
   assign prime_idx = 2'(cnt_ff - 3'd1);
   assign tail_prod = $signed(word_ff[7:0]) * $signed({1'b0, tail_prime(prime_idx)});
   assign tail_ext  = {{(HashWidth-21){tail_prod[20]}}, tail_prod};

   // One restoring step of the remainder: shift in the next dividend bit and
   // subtract the divisor when it fits. The remainder stays below 2^24.
   assign trial     = {rem_ff, dvd_ff[HashWidth-1]};
   assign trial_sub = trial - divisor;

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      word_in      = word_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      rsp_hash_in  = rsp_hash_ff;
      rsp_index_in = rsp_index_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               word_in  = req_key_word;
               cnt_in   = count_clamp;
               last_in  = req_last_word;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // A full word folds in at once; a short word takes one byte per cycle.
            if (cnt_ff == FULL_COUNT) begin
               sum_in = (sum_ff << 5) + sum_ff + {{(HashWidth-KeyWidth){1'b0}}, word_ff};
               cnt_in = '0;
            end else if (cnt_ff != '0) begin
               sum_in  = sum_ff + tail_ext;
               word_in = word_ff >> 8;
               cnt_in  = cnt_ff - 3'd1;
            end
            if ((cnt_ff == FULL_COUNT) || (cnt_ff <= 3'd1)) begin
               if (last_ff) begin
                  dvd_in   = sum_in;
                  rem_in   = '0;
                  step_in  = '0;
                  state_in = ST_DIVIDE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIVIDE: begin
            if (trial >= divisor) begin
               rem_in = trial_sub[IndexWidth-1:0];
            end else begin
               rem_in = trial[IndexWidth-1:0];
            end
            dvd_in  = dvd_ff << 1;
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd63) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Wait for the output register to free up, then start a new key.
            if (out_free) begin
               rsp_hash_in  = sum_ff;
               rsp_index_in = rem_ff;
               rsp_valid_in = 1'b1;
               sum_in       = HASH_SEED;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= HASH_SEED;
         table_ff     <= TABLE_RESET;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         last_ff      <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         step_ff      <= step_in;
         if (csr_write) begin
            table_ff <= csr_table_size;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff      <= word_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      rsp_hash_ff  <= rsp_hash_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hash_value   = rsp_hash_ff;
   assign rsp_bucket_index = rsp_index_ff;

endmodule
